// ===== hdl/btim_pkg.sv =====
// ----------------------------------------------------------------------------
// Box table IoU merge package
// Shared types, codes and helpers for the box table with greedy IoU merge.
// ----------------------------------------------------------------------------
`default_nettype none

package btim_pkg;

  localparam int CoordFracBits = 4;
  localparam int TruncBorder   = 3;
  localparam int MaxOut        = 32;
  localparam int DefTableDepth = 32;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 17;
  localparam int CoordW        = 18;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DUMP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    STS_APPENDED   = 4'd0,
    STS_SAME_CLASS = 4'd1,
    STS_NEW_CLASS  = 4'd2,
    STS_IGNORED    = 4'd3,
    STS_TRUNCATED  = 4'd4,
    STS_AREA       = 4'd5,
    STS_FULL       = 4'd6,
    STS_CLEARED    = 4'd7,
    STS_ENTRY      = 4'd8,
    STS_EMPTY      = 4'd9
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_IOU_THR  = 3'd2,
    REG_DROP_TRC = 3'd3,
    REG_MIN_AREA = 3'd4,
    REG_MAX_AREA = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_AREA_LO,
    ST_AREA_HI,
    ST_FILTER,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_WRITE,
    ST_DUMP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] left_edge;
    logic signed [15:0] top_edge;
    logic signed [15:0] right_edge;
    logic signed [15:0] bottom_edge;
    logic [7:0]         class_label;
    logic [31:0]        object_id;
    logic [15:0]        track_count;
    logic [15:0]        confidence;
    logic               refine_allowed;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [4:0]         slot;
    logic signed [15:0] out_left;
    logic signed [15:0] out_top;
    logic signed [15:0] out_right;
    logic signed [15:0] out_bottom;
    logic [7:0]         out_class;
    logic [31:0]        out_id;
    logic [15:0]        out_track_count;
    logic [15:0]        out_confidence;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
    logic [7:0]         cls;
    logic [31:0]        id;
    logic [15:0]        trk;
    logic [15:0]        conf;
  } entry_t;

  function automatic logic signed [CoordW-1:0] sx(input logic signed [15:0] v);
    return {{(CoordW-16){v[15]}}, v};
  endfunction

  function automatic logic signed [CoordW-1:0] smax(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CoordW-1:0] smin(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CoordW-1:0] img_q(input logic [11:0] px);
    return CoordW'({px, {CoordFracBits{1'b0}}});
  endfunction

  function automatic out_word_t mk_out(input status_t st, input logic [4:0] slot,
                                       input entry_t e, input logic last);
    out_word_t o;
    o.status          = st;
    o.slot            = slot;
    o.out_left        = e.l;
    o.out_top         = e.t;
    o.out_right       = e.r;
    o.out_bottom      = e.b;
    o.out_class       = e.cls;
    o.out_id          = e.id;
    o.out_track_count = e.trk;
    o.out_confidence  = e.conf;
    o.last            = last;
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/btim_cell.sv =====
// ----------------------------------------------------------------------------
// Box table cell
// Holds one table entry and takes its neighbor's entry when the ring rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module btim_cell (
  input  wire logic            clk,
  input  wire logic            shift_en,
  input  wire btim_pkg::entry_t d,
  output btim_pkg::entry_t     q
);

  btim_pkg::entry_t ent_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r <= d;
    end
  end

  assign q = ent_r;

endmodule

`default_nettype wire

// ===== hdl/btim_iou.sv =====
// ----------------------------------------------------------------------------
// Box table IoU compare pipeline
// Five stages: clip, products, union, threshold product, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module btim_iou #(
  parameter int SLOT_W = 6
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_vld,
  input  wire logic [SLOT_W-1:0]                     in_slot,
  input  wire btim_pkg::entry_t                      ent_a,
  input  wire btim_pkg::entry_t                      ent_b,
  input  wire logic signed [btim_pkg::CoordW-1:0]    wq,
  input  wire logic signed [btim_pkg::CoordW-1:0]    hq,
  input  wire logic [16:0]                           thr,
  output logic                                       res_vld,
  output logic                                       res_match,
  output logic [SLOT_W-1:0]                          res_slot,
  output btim_pkg::entry_t                           res_ent
);

  localparam int L = 5;
  localparam int CW = btim_pkg::CoordW;

  logic [L-1:0]       vld_r;
  logic [SLOT_W-1:0]  slot_r [L];
  btim_pkg::entry_t   ent_r  [L];

  logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, iw, ih;
  logic signed [CW-1:0] wa_r, ha_r, wb_r, hb_r, iw_r, ih_r;
  logic signed [2*CW-1:0] area_a_r, area_b_r, inter_r, inter2_r, inter3_r;
  logic signed [2*CW:0]   uni_r;
  logic                   pos_r, match_r;
  logic [50:0]            prod_r;

  always_comb begin
    ax0 = btim_pkg::smax(btim_pkg::sx(ent_a.l), '0);
    ay0 = btim_pkg::smax(btim_pkg::sx(ent_a.t), '0);
    ax1 = btim_pkg::smin(btim_pkg::sx(ent_a.r), wq);
    ay1 = btim_pkg::smin(btim_pkg::sx(ent_a.b), hq);
    bx0 = btim_pkg::smax(btim_pkg::sx(ent_b.l), '0);
    by0 = btim_pkg::smax(btim_pkg::sx(ent_b.t), '0);
    bx1 = btim_pkg::smin(btim_pkg::sx(ent_b.r), wq);
    by1 = btim_pkg::smin(btim_pkg::sx(ent_b.b), hq);
    iw  = btim_pkg::smax(btim_pkg::smin(ax1, bx1) - btim_pkg::smax(ax0, bx0), '0);
    ih  = btim_pkg::smax(btim_pkg::smin(ay1, by1) - btim_pkg::smax(ay0, by0), '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[L-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= in_slot;
    ent_r[0]  <= ent_a;
    for (int i = 1; i < L; i++) begin
      slot_r[i] <= slot_r[i-1];
      ent_r[i]  <= ent_r[i-1];
    end
    wa_r <= ax1 - ax0;
    ha_r <= ay1 - ay0;
    wb_r <= bx1 - bx0;
    hb_r <= by1 - by0;
    iw_r <= iw;
    ih_r <= ih;
    area_a_r <= wa_r * ha_r;
    area_b_r <= wb_r * hb_r;
    inter_r  <= iw_r * ih_r;
    uni_r    <= (2*CW+1)'(area_a_r) + (2*CW+1)'(area_b_r) - (2*CW+1)'(inter_r);
    inter2_r <= inter_r;
    pos_r    <= (uni_r > 0);
    prod_r   <= {34'd0, thr} * {17'd0, uni_r[33:0]};
    inter3_r <= inter2_r;
    match_r  <= pos_r && ({3'd0, inter3_r[31:0], 16'd0} > prod_r);
  end

  assign res_vld   = vld_r[L-1];
  assign res_match = match_r;
  assign res_slot  = slot_r[L-1];
  assign res_ent   = ent_r[L-1];

endmodule

`default_nettype wire

// ===== hdl/box_table_iou_merge_top.sv =====
// ----------------------------------------------------------------------------
// Box table IoU merge top level
// Table of tracked boxes held in a rotating ring of cells, with greedy merge.
// ----------------------------------------------------------------------------
// Usage: send one command word on in_valid/in_data; in_stall is high while a
// command is in progress. Clear and add give one word on out_valid/out_data;
// dump gives one word per stored entry, at most MaxOut (last set on the
// final one), or a single table-empty word. Configuration writes arrive
// on cfg_valid with cfg_index/cfg_data and are always taken (cfg_ready high).
// Sequence: an add runs its filter checks (CHK, AREA_LO, AREA_HI, FILTER;
// a dropped box goes straight to the emit state), then rotates the ring
// once past the IoU pipeline and drains it, decides, rotates the ring a
// second time when an entry is written, and emits. Clear goes straight to
// the emit state; a dump rotates the ring once, pausing on receiver stalls.
// The ring moves one cell per cycle unless a dump waits on the receiver.
// Reset empties the table, sets the next id to 1 and loads register
// defaults. When the receiver stalls, the output word holds and the ring
// pauses until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module box_table_iou_merge_top #(
  parameter int TABLE_DEPTH = btim_pkg::DefTableDepth
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire btim_pkg::in_word_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output btim_pkg::out_word_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [btim_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [btim_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int KW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = btim_pkg::CoordW;
  localparam logic [KW-1:0] LastK = KW'(TABLE_DEPTH - 1);
  localparam logic [KW-1:0] Depth = KW'(TABLE_DEPTH);

  btim_pkg::state_t state_r, state_nxt;

  logic [11:0] img_w_r, img_h_r;
  logic [16:0] thr_r, min_fr_r, max_fr_r;
  logic        drop_en_r;

  logic [KW-1:0] count_r, k_r, target_r, m_slot_r, dump_n;
  logic [31:0]   next_id_r;
  logic [2:0]    drain_r;
  logic          found_r, refine_r, trunc_r, lo_fail_r;
  btim_pkg::entry_t nb_r, m_ent_r, dec_ent, tail_d;
  btim_pkg::out_word_t res_r, dec_res, out_r;
  btim_pkg::status_t   dec_sts;
  logic          out_valid_r, out_free, out_load;
  logic          shift_en, tail_wr, dump_emit, iou_vld;
  logic          dec_write, dec_take_id, dec_append;
  logic [KW-1:0] dec_target;

  logic [14:0] cw_r, ch_r;
  logic [23:0] wh_r;
  logic [29:0] carea_r;
  logic [48:0] lim_r;
  logic [31:0] img_area;
  logic [45:0] lhs;
  logic signed [CW-1:0] wq, hq, ccw, cch, xr, yr;
  logic        trunc_c;

  btim_pkg::entry_t cell_q [TABLE_DEPTH];
  btim_pkg::entry_t in_ent;

  logic              iou_res_vld, iou_res_match;
  logic [KW-1:0]     iou_res_slot;
  btim_pkg::entry_t  iou_res_ent;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != btim_pkg::ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = dump_emit || ((state_r == btim_pkg::ST_EMIT) && out_free);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign in_ent.l    = in_data.left_edge;
  assign in_ent.t    = in_data.top_edge;
  assign in_ent.r    = in_data.right_edge;
  assign in_ent.b    = in_data.bottom_edge;
  assign in_ent.cls  = in_data.class_label;
  assign in_ent.id   = in_data.object_id;
  assign in_ent.trk  = in_data.track_count;
  assign in_ent.conf = in_data.confidence;

  assign dump_n = (32'(count_r) > 32'(btim_pkg::MaxOut)) ? KW'(btim_pkg::MaxOut) : count_r;

  assign wq  = btim_pkg::img_q(img_w_r);
  assign hq  = btim_pkg::img_q(img_h_r);
  assign ccw = btim_pkg::smax(btim_pkg::smin(btim_pkg::sx(nb_r.r), wq)
                              - btim_pkg::smax(btim_pkg::sx(nb_r.l), '0), '0);
  assign cch = btim_pkg::smax(btim_pkg::smin(btim_pkg::sx(nb_r.b), hq)
                              - btim_pkg::smax(btim_pkg::sx(nb_r.t), '0), '0);
  assign xr  = (CW'($signed({1'b0, img_w_r})) - CW'(btim_pkg::TruncBorder))
               <<< btim_pkg::CoordFracBits;
  assign yr  = (CW'($signed({1'b0, img_h_r})) - CW'(btim_pkg::TruncBorder))
               <<< btim_pkg::CoordFracBits;
  assign trunc_c = (btim_pkg::sx(nb_r.l) < CW'(btim_pkg::TruncBorder << btim_pkg::CoordFracBits))
                || (btim_pkg::sx(nb_r.t) < CW'(btim_pkg::TruncBorder << btim_pkg::CoordFracBits))
                || (btim_pkg::sx(nb_r.r) >= xr) || (btim_pkg::sx(nb_r.b) >= yr);
  assign img_area = {wh_r, {(2*btim_pkg::CoordFracBits){1'b0}}};
  assign lhs      = {carea_r, 16'd0};

  // ring of cells: the head is cell 0, the tail takes the head or a new entry
  assign tail_d = tail_wr ? nb_r : cell_q[0];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    btim_pkg::entry_t d;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign d = tail_d;
    end else begin : g_mid
      assign d = cell_q[i+1];
    end
    btim_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d        (d),
      .q        (cell_q[i])
    );
  end

  assign iou_vld = (state_r == btim_pkg::ST_SCAN) && (k_r < count_r);

  btim_iou #(.SLOT_W(KW)) u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (iou_vld),
    .in_slot   (k_r),
    .ent_a     (cell_q[0]),
    .ent_b     (nb_r),
    .wq        (wq),
    .hq        (hq),
    .thr       (thr_r),
    .res_vld   (iou_res_vld),
    .res_match (iou_res_match),
    .res_slot  (iou_res_slot),
    .res_ent   (iou_res_ent)
  );

  always_comb begin
    dec_ent     = nb_r;
    dec_sts     = btim_pkg::STS_APPENDED;
    dec_write   = 1'b0;
    dec_take_id = 1'b0;
    dec_append  = 1'b0;
    dec_target  = count_r;
    if (found_r) begin
      dec_target = m_slot_r;
      if (!refine_r) begin
        dec_ent = m_ent_r;
        dec_sts = btim_pkg::STS_IGNORED;
      end else if (m_ent_r.cls == nb_r.cls) begin
        dec_ent.id  = m_ent_r.id;
        dec_ent.trk = m_ent_r.trk;
        dec_sts     = btim_pkg::STS_SAME_CLASS;
        dec_write   = 1'b1;
      end else begin
        dec_take_id = (nb_r.id == 32'd0);
        if (dec_take_id) begin
          dec_ent.id = next_id_r;
        end
        dec_sts   = btim_pkg::STS_NEW_CLASS;
        dec_write = 1'b1;
      end
    end else if (count_r == Depth) begin
      dec_sts = btim_pkg::STS_FULL;
    end else begin
      dec_take_id = (nb_r.id == 32'd0);
      if (dec_take_id) begin
        dec_ent.id = next_id_r;
      end
      dec_write  = 1'b1;
      dec_append = 1'b1;
    end
    dec_res = btim_pkg::mk_out(dec_sts,
                               (dec_sts == btim_pkg::STS_FULL) ? 5'd0 : 5'(dec_target),
                               dec_ent, 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    shift_en  = 1'b0;
    tail_wr   = 1'b0;
    dump_emit = 1'b0;
    unique case (state_r)
      btim_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (btim_pkg::cmd_t'(in_data.command))
            btim_pkg::CMD_CLEAR: state_nxt = btim_pkg::ST_EMIT;
            btim_pkg::CMD_ADD:   state_nxt = btim_pkg::ST_CHK;
            btim_pkg::CMD_DUMP:  state_nxt = (count_r == '0) ? btim_pkg::ST_EMIT
                                                             : btim_pkg::ST_DUMP;
            default:             state_nxt = btim_pkg::ST_IDLE;
          endcase
        end
      end
      btim_pkg::ST_CHK:     state_nxt = btim_pkg::ST_AREA_LO;
      btim_pkg::ST_AREA_LO: state_nxt = btim_pkg::ST_AREA_HI;
      btim_pkg::ST_AREA_HI: state_nxt = btim_pkg::ST_FILTER;
      btim_pkg::ST_FILTER: begin
        if ((drop_en_r && trunc_r) || lo_fail_r || ({3'd0, lhs} > lim_r)) begin
          state_nxt = btim_pkg::ST_EMIT;
        end else begin
          state_nxt = btim_pkg::ST_SCAN;
        end
      end
      btim_pkg::ST_SCAN: begin
        shift_en = 1'b1;
        if (k_r == LastK) begin
          state_nxt = btim_pkg::ST_DRAIN;
        end
      end
      btim_pkg::ST_DRAIN: begin
        if (drain_r == 3'd0) begin
          state_nxt = btim_pkg::ST_DECIDE;
        end
      end
      btim_pkg::ST_DECIDE: state_nxt = dec_write ? btim_pkg::ST_WRITE : btim_pkg::ST_EMIT;
      btim_pkg::ST_WRITE: begin
        shift_en = 1'b1;
        tail_wr  = (k_r == target_r);
        if (k_r == LastK) begin
          state_nxt = btim_pkg::ST_EMIT;
        end
      end
      btim_pkg::ST_DUMP: begin
        if (k_r < dump_n) begin
          shift_en  = out_free;
          dump_emit = out_free;
        end else begin
          shift_en = 1'b1;
        end
        if (shift_en && (k_r == LastK)) begin
          state_nxt = btim_pkg::ST_IDLE;
        end
      end
      btim_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = btim_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btim_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btim_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= 12'd640;
      img_h_r   <= 12'd480;
      thr_r     <= 17'd13107;
      drop_en_r <= 1'b1;
      min_fr_r  <= 17'd0;
      max_fr_r  <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (btim_pkg::reg_idx_t'(cfg_index))
        btim_pkg::REG_WIDTH:    img_w_r   <= cfg_data[11:0];
        btim_pkg::REG_HEIGHT:   img_h_r   <= cfg_data[11:0];
        btim_pkg::REG_IOU_THR:  thr_r     <= cfg_data;
        btim_pkg::REG_DROP_TRC: drop_en_r <= cfg_data[0];
        btim_pkg::REG_MIN_AREA: min_fr_r  <= cfg_data;
        btim_pkg::REG_MAX_AREA: max_fr_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      next_id_r   <= 32'd1;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      k_r         <= '0;
      drain_r     <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
      if (shift_en) begin
        k_r <= (k_r == LastK) ? '0 : k_r + 1'b1;
      end
      unique case (state_r)
        btim_pkg::ST_IDLE: begin
          k_r <= '0;
          if (in_valid) begin
            nb_r     <= in_ent;
            refine_r <= in_data.refine_allowed;
            if (in_data.command == btim_pkg::CMD_CLEAR) begin
              count_r <= '0;
              res_r   <= btim_pkg::mk_out(btim_pkg::STS_CLEARED, 5'd0, '0, 1'b1);
            end else begin
              res_r   <= btim_pkg::mk_out(btim_pkg::STS_EMPTY, 5'd0, '0, 1'b1);
            end
          end
        end
        btim_pkg::ST_CHK: begin
          trunc_r <= trunc_c;
          cw_r    <= ccw[14:0];
          ch_r    <= cch[14:0];
          wh_r    <= img_w_r * img_h_r;
        end
        btim_pkg::ST_AREA_LO: begin
          carea_r <= cw_r * ch_r;
          lim_r   <= {15'd0, min_fr_r} * {17'd0, img_area};
        end
        btim_pkg::ST_AREA_HI: begin
          lo_fail_r <= {3'd0, lhs} < lim_r;
          lim_r     <= {15'd0, max_fr_r} * {17'd0, img_area};
        end
        btim_pkg::ST_FILTER: begin
          found_r <= 1'b0;
          k_r     <= '0;
          drain_r <= 3'd5;
          if (drop_en_r && trunc_r) begin
            res_r <= btim_pkg::mk_out(btim_pkg::STS_TRUNCATED, 5'd0, nb_r, 1'b1);
          end else if (lo_fail_r || ({3'd0, lhs} > lim_r)) begin
            res_r <= btim_pkg::mk_out(btim_pkg::STS_AREA, 5'd0, nb_r, 1'b1);
          end
        end
        btim_pkg::ST_SCAN, btim_pkg::ST_DRAIN: begin
          if (state_r == btim_pkg::ST_DRAIN) begin
            drain_r <= drain_r - 3'd1;
          end
          if (iou_res_vld && iou_res_match && !found_r) begin
            found_r  <= 1'b1;
            m_slot_r <= iou_res_slot;
            m_ent_r  <= iou_res_ent;
          end
        end
        btim_pkg::ST_DECIDE: begin
          k_r      <= '0;
          res_r    <= dec_res;
          nb_r     <= dec_ent;
          target_r <= dec_target;
          if (dec_append) begin
            count_r <= count_r + 1'b1;
          end
          if (dec_take_id) begin
            next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
          end
        end
        btim_pkg::ST_DUMP: begin
          if (dump_emit) begin
            out_r <= btim_pkg::mk_out(btim_pkg::STS_ENTRY, 5'(k_r), cell_q[0],
                                      (k_r + 1'b1) == dump_n);
          end
        end
        btim_pkg::ST_EMIT: begin
          if (out_free) begin
            out_r <= res_r;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
